// ===== hw/rtl/sha256_reduced_pair_diff_check_unit_defines.svh =====
// Assertion macros shared by the checker of the reduced SHA-256 pair check.
// Depends on nothing; included by the checker file only.
`ifndef SHA256_REDUCED_PAIR_DIFF_CHECK_UNIT_DEFINES_SVH
`define SHA256_REDUCED_PAIR_DIFF_CHECK_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SRP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define SRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

// ===== hw/rtl/srpdc_pkg.sv =====
// Package for the reduced SHA-256 pair difference checker: constants, types
// and round functions. Depends on nothing.
package srpdc_pkg;
   localparam int unsigned Rounds = 57;
   localparam int unsigned WordW = 32;
   localparam int unsigned WeightW = 9;
   localparam int unsigned ScanW = 4;
   localparam int unsigned CsrIdxW = 2;

   typedef logic [WordW-1:0] word_type;
   typedef word_type state_type [8];
   typedef word_type sched_type [16];

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SCAN_INDEX  = 2'd0,
      CSR_FIRST_WORD  = 2'd1,
      CSR_FILL_WORD   = 2'd2,
      CSR_KERNEL_MASK = 2'd3
   } csr_index_type;

   localparam logic [ScanW-1:0] ScanReset = 4'd1;
   localparam word_type FirstReset = 32'h17149975;
   localparam word_type FillReset = 32'hffffffff;
   localparam word_type KernelReset = 32'h80000000;
   localparam logic [ScanW-1:0] KernelWordB = 4'd9;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam state_type InitState = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // Config register values; the message blocks are built from them as each
   // transaction is accepted, so a later write cannot disturb items in flight.
   typedef struct packed {
      logic [ScanW-1:0] scan_index;
      word_type first_word;
      word_type fill_word;
      word_type kernel_mask;
   } csr_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WordW - n));
   endfunction

   // One round: state and schedule word in, next state out.
   function automatic state_type round_step(input state_type v, input word_type k,
                                            input word_type w);
      word_type big1, ch, t1, big0, maj, t2;
      state_type r;
      big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + big1 + ch + k + w;
      big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = big0 + maj;
      r[7] = v[6]; r[6] = v[5]; r[5] = v[4]; r[4] = v[3] + t1;
      r[3] = v[2]; r[2] = v[1]; r[1] = v[0]; r[0] = t1 + t2;
      return r;
   endfunction

   // Slide the 16-word schedule window by one, appending the next word.
   function automatic sched_type sched_step(input sched_type w);
      word_type s0, s1;
      sched_type r;
      s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
      s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
      for (int i = 0; i < 15; i++) begin
         r[i] = w[i+1];
      end
      r[15] = s1 + w[9] + s0 + w[0];
      return r;
   endfunction

   function automatic logic [5:0] popcount32(input word_type x);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < WordW; i++) begin
         n = n + {5'd0, x[i]};
      end
      return n;
   endfunction
endpackage

// ===== hw/rtl/srpdc_round_stage.sv =====
// One pipeline stage: a single SHA-256 round for both blocks of the pair,
// with schedule window, candidate and valid carried along. Uses srpdc_pkg.
module srpdc_round_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  srpdc_pkg::word_type  in_cand,
   input  srpdc_pkg::word_type  round_k,
   input  srpdc_pkg::state_type in_st1,
   input  srpdc_pkg::state_type in_st2,
   input  srpdc_pkg::sched_type in_w1,
   input  srpdc_pkg::sched_type in_w2,
   output logic                 out_valid,
   output srpdc_pkg::word_type  out_cand,
   output srpdc_pkg::state_type out_st1,
   output srpdc_pkg::state_type out_st2,
   output srpdc_pkg::sched_type out_w1,
   output srpdc_pkg::sched_type out_w2
);
   import srpdc_pkg::*;

   logic valid_ff;
   word_type cand_ff;
   state_type st1_ff, st2_ff;
   sched_type w1_ff, w2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cand_ff <= in_cand;
         st1_ff <= round_step(in_st1, round_k, in_w1[0]);
         st2_ff <= round_step(in_st2, round_k, in_w2[0]);
         w1_ff <= sched_step(in_w1);
         w2_ff <= sched_step(in_w2);
      end
   end

   assign out_valid = valid_ff;
   assign out_cand = cand_ff;
   assign out_st1 = st1_ff;
   assign out_st2 = st2_ff;
   assign out_w1 = w1_ff;
   assign out_w2 = w2_ff;
endmodule

// ===== hw/rtl/srpdc_diff_stage.sv =====
// Final stages: compare a words, form XOR differences, then sum the weight.
// Uses srpdc_pkg.
module srpdc_diff_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  srpdc_pkg::word_type  in_cand,
   input  srpdc_pkg::state_type in_st1,
   input  srpdc_pkg::state_type in_st2,
   output logic                 out_valid,
   output srpdc_pkg::word_type  out_cand,
   output logic [srpdc_pkg::WeightW-1:0] out_weight,
   output srpdc_pkg::state_type out_diff
);
   import srpdc_pkg::*;

   logic v1_ff, v2_ff;
   word_type cand1_ff, cand2_ff;
   state_type diff1_ff, diff2_ff;
   logic [5:0] cnt_ff [8];
   logic [WeightW-1:0] weight_ff;
   logic [WeightW-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 8; i++) begin
         sum_in = sum_in + {3'd0, cnt_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         // Misses drop out here: only equal a words go on.
         v1_ff <= in_valid && (in_st1[0] == in_st2[0]);
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cand1_ff <= in_cand;
         for (int i = 0; i < 8; i++) begin
            diff1_ff[i] <= in_st1[i] ^ in_st2[i];
            cnt_ff[i] <= popcount32(in_st1[i] ^ in_st2[i]);
         end
         cand2_ff <= cand1_ff;
         diff2_ff <= diff1_ff;
         weight_ff <= sum_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_cand = cand2_ff;
   assign out_weight = weight_ff;
   assign out_diff = diff2_ff;
endmodule

// ===== hw/rtl/sha256_reduced_pair_diff_check_unit.sv =====
// Top level of the reduced-round SHA-256 pair difference checker.
// Uses srpdc_pkg, srpdc_round_stage and srpdc_diff_stage.
//
// Usage: each req_ transaction carries one candidate for the scanned word.
// Two message blocks are built from the csr_ registers (the second with the
// kernel mask on words 0 and 9), both run 57 rounds from the SHA-256 IV, and
// a rsp_ transaction appears only when the final a words match.
// Pipeline: 1 build stage + 57 round stages + 2 compare/weight stages.
// Throughput: one candidate per cycle while the pipe is not stalled; each round
// stage holds a round adder chain for each of the two blocks.
// The whole pipe moves together: rsp_stall high with a result waiting holds
// every stage and raises req_stall; empty slots let the pipe keep moving.
// Reset clears all valid bits and loads the register defaults (scan index 1,
// first word 0x17149975, fill 0xffffffff, kernel 0x80000000).
// Register writes are taken on any cycle; change them only when idle.
module sha256_reduced_pair_diff_check_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [31:0]                  req_candidate_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [31:0]                  rsp_hit_value,
   output logic [8:0]                   rsp_total_weight,
   output logic [31:0]                  rsp_diff_b,
   output logic [31:0]                  rsp_diff_c,
   output logic [31:0]                  rsp_diff_d,
   output logic [31:0]                  rsp_diff_e,
   output logic [31:0]                  rsp_diff_f,
   output logic [31:0]                  rsp_diff_g,
   output logic [31:0]                  rsp_diff_h,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [srpdc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                  csr_data
);
   import srpdc_pkg::*;

   csr_type csr_ff, csr_in;
   logic advance;
   logic b_valid_ff;
   word_type b_cand_ff;
   sched_type b_w1_ff, b_w2_ff;
   sched_type m1_in, m2_in;

   logic p_valid [Rounds+1];
   word_type p_cand [Rounds+1];
   state_type p_st1 [Rounds+1];
   state_type p_st2 [Rounds+1];
   sched_type p_w1 [Rounds+1];
   sched_type p_w2 [Rounds+1];
   state_type diff;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCAN_INDEX:  csr_in.scan_index = csr_data[ScanW-1:0];
            CSR_FIRST_WORD:  csr_in.first_word = csr_data;
            CSR_FILL_WORD:   csr_in.fill_word = csr_data;
            CSR_KERNEL_MASK: csr_in.kernel_mask = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.scan_index <= ScanReset;
         csr_ff.first_word <= FirstReset;
         csr_ff.fill_word <= FillReset;
         csr_ff.kernel_mask <= KernelReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // The pipe freezes only when a finished result is held by the receiver.
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         m1_in[i] = csr_ff.fill_word;
         m2_in[i] = csr_ff.fill_word;
      end
      m1_in[0] = csr_ff.first_word;
      m2_in[0] = csr_ff.first_word ^ csr_ff.kernel_mask;
      m2_in[KernelWordB] = csr_ff.fill_word ^ csr_ff.kernel_mask;
      m1_in[csr_ff.scan_index] = req_candidate_value;
      m2_in[csr_ff.scan_index] = req_candidate_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_cand_ff <= req_candidate_value;
         b_w1_ff <= m1_in;
         b_w2_ff <= m2_in;
      end
   end

   assign p_valid[0] = b_valid_ff;
   assign p_cand[0] = b_cand_ff;
   assign p_st1[0] = InitState;
   assign p_st2[0] = InitState;
   assign p_w1[0] = b_w1_ff;
   assign p_w2[0] = b_w2_ff;

   for (genvar r = 0; r < Rounds; r++) begin : g_round
      srpdc_round_stage u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (p_valid[r]),
         .in_cand   (p_cand[r]),
         .round_k   (RoundK[r]),
         .in_st1    (p_st1[r]),
         .in_st2    (p_st2[r]),
         .in_w1     (p_w1[r]),
         .in_w2     (p_w2[r]),
         .out_valid (p_valid[r+1]),
         .out_cand  (p_cand[r+1]),
         .out_st1   (p_st1[r+1]),
         .out_st2   (p_st2[r+1]),
         .out_w1    (p_w1[r+1]),
         .out_w2    (p_w2[r+1])
      );
   end

   srpdc_diff_stage u_diff (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (p_valid[Rounds]),
      .in_cand    (p_cand[Rounds]),
      .in_st1     (p_st1[Rounds]),
      .in_st2     (p_st2[Rounds]),
      .out_valid  (rsp_valid),
      .out_cand   (rsp_hit_value),
      .out_weight (rsp_total_weight),
      .out_diff   (diff)
   );

   assign rsp_diff_b = diff[1];
   assign rsp_diff_c = diff[2];
   assign rsp_diff_d = diff[3];
   assign rsp_diff_e = diff[4];
   assign rsp_diff_f = diff[5];
   assign rsp_diff_g = diff[6];
   assign rsp_diff_h = diff[7];
endmodule

// ===== hw/rtl/srpdc_checker.sv =====
// Port-level checker for the reduced SHA-256 pair difference checker, bound
// to the top level. Uses the macros of the unit's defines header.
`include "sha256_reduced_pair_diff_check_unit_defines.svh"
module srpdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_hit_value,
   input logic [8:0]  rsp_total_weight,
   input logic        csr_ready
);
   `SRP_ASSERT_IMP(a_stall_follows_out, clock, reset, req_stall, rsp_valid && rsp_stall)
   `SRP_ASSERT_IMP(a_out_blocks_in, clock, reset, rsp_valid && rsp_stall, req_stall)
   `SRP_ASSERT_NEXT(a_hold_value, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hit_value) && $stable(rsp_total_weight))
   `SRP_ASSERT_IMP(a_weight_range, clock, reset, rsp_valid, rsp_total_weight <= 9'd256)
   `SRP_ASSERT_IMP(a_csr_open, clock, reset, 1'b1, csr_ready)
endmodule

bind sha256_reduced_pair_diff_check_unit srpdc_checker u_srpdc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit_value    (rsp_hit_value),
   .rsp_total_weight (rsp_total_weight),
   .csr_ready        (csr_ready)
);
